/* design/gda_pkg.sv */
// ----------------------------------------------------------------------------
// gda_pkg: shared definitions for the gregorian date adder
// Field widths, calendar constants and the month length lookup.
// ----------------------------------------------------------------------------
package gda_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int COUNT_W = 15;
  // year position inside the 400 year leap cycle
  localparam int CYCLE_W = 9;

  typedef logic [DAY_W-1:0]   day_t;
  typedef logic [MONTH_W-1:0] month_t;
  typedef logic [YEAR_W-1:0]  year_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CYCLE_W-1:0] cycle_t;

  localparam year_t  YEAR_MAX     = 14'd9999;
  localparam year_t  LEAP_CYCLE   = 14'd400;
  localparam cycle_t CYCLE_LAST   = 9'd399;
  localparam cycle_t CENTURY_1    = 9'd100;
  localparam cycle_t CENTURY_2    = 9'd200;
  localparam cycle_t CENTURY_3    = 9'd300;
  localparam month_t MONTH_JAN    = 4'd1;
  localparam month_t MONTH_FEB    = 4'd2;
  localparam month_t MONTH_DEC    = 4'd12;
  localparam day_t   DAY_FIRST    = 5'd1;
  localparam day_t   DAY_LAST_DEC = 5'd31;
  localparam day_t   FEB_LEAP_LEN = 5'd29;

  // days per month, January first, February in a common year
  localparam day_t MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // length of a month, zero for a month code outside january..december
  function automatic day_t month_length(input month_t month, input logic leap);
    day_t len;
    len = '0;
    if (month >= MONTH_JAN && month <= MONTH_DEC) begin
      len = MONTH_LEN[month - MONTH_JAN];
      if (month == MONTH_FEB && leap) begin
        len = FEB_LEAP_LEN;
      end
    end
    return len;
  endfunction

endpackage

/* design/gda_req_if.sv */
// ----------------------------------------------------------------------------
// gda_req_if: request channel of the date adder
// Start date and day count with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gda_req_if;
  import gda_pkg::*;

  logic   valid;
  logic   ready;
  day_t   start_day;
  month_t start_month;
  year_t  start_year;
  count_t days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink   (input valid, start_day, start_month, start_year, days_to_add,
                  output ready);
endinterface

/* design/gda_res_if.sv */
// ----------------------------------------------------------------------------
// gda_res_if: result channel of the date adder
// Resulting date and status flags with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface gda_res_if;
  import gda_pkg::*;

  logic   valid;
  logic   ready;
  day_t   result_day;
  month_t result_month;
  year_t  result_year;
  logic   bad_start;
  logic   year_overflow;

  modport source (output valid, result_day, result_month, result_year, bad_start,
                  year_overflow, input ready);
  modport sink   (input valid, result_day, result_month, result_year, bad_start,
                  year_overflow, output ready);
endinterface

/* design/gda_month_len.sv */
// ----------------------------------------------------------------------------
// gda_month_len: month length lookup
// Gives the days in a month from the month code and the year position
// inside the 400 year cycle, with the 400/100/4 leap rule.
// ----------------------------------------------------------------------------
module gda_month_len (
  input  gda_pkg::month_t month,
  input  gda_pkg::cycle_t year_pos,
  output gda_pkg::day_t   len
);
  import gda_pkg::*;

  logic leap;

  // divisible by 4, not a plain century; position zero is the 400th year
  assign leap = (year_pos[1:0] == 2'b00) && (year_pos != CENTURY_1) &&
                (year_pos != CENTURY_2) && (year_pos != CENTURY_3);

  assign len = month_length(month, leap);

endmodule

/* design/gregorian_date_add_days_top.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_days_top: gregorian date plus a day count
// Walks the calendar one month per cycle on a single shared subtractor.
// ----------------------------------------------------------------------------
// One request is taken at a time; ready is low while it is worked on. A
// request first reduces the start year into the 400 year leap cycle (one
// subtract of 400 per cycle), then checks the start date and, if it is
// valid, walks the calendar month by month into the final partial month.
// The month walk on the shared subtractor takes the most time for a large
// day count. A finished result waits in the output register while the next
// request is accepted; an invalid start date is echoed with bad_start set,
// and a walk past year 9999 stops at 31/12/9999 with year_overflow set.
module gregorian_date_add_days_top (
  input logic clk,
  input logic rst,
  gda_req_if.sink   request,
  gda_res_if.source result
);
  import gda_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state;
  day_t       d;
  month_t     m;
  year_t      y;
  year_t      ypos;
  count_t     rem;
  logic       bad;
  logic       ovf;
  logic       res_valid;

  day_t       mlen;
  day_t       step_len;
  count_t     sub_a;
  count_t     sub_b;
  logic [COUNT_W:0] sub_diff;
  logic       sub_borrow;
  logic       start_bad;
  logic       res_load;

  // month length for the current walk position
  gda_month_len u_month_len (
    .month    (m),
    .year_pos (ypos[CYCLE_W-1:0]),
    .len      (mlen)
  );

  // days from the current day through the end of the month
  assign step_len = mlen - d + DAY_FIRST;

  // shared subtractor: year reduction or month step
  always_comb begin
    if (state == ST_MOD) begin
      sub_a = COUNT_W'(ypos);
      sub_b = COUNT_W'(LEAP_CYCLE);
    end else begin
      sub_a = rem;
      sub_b = COUNT_W'(step_len);
    end
  end
  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[COUNT_W];

  // start date check
  assign start_bad = (m < MONTH_JAN) || (m > MONTH_DEC) || (y == '0) ||
                     (y > YEAR_MAX) || (d == '0) || (d > mlen);

  assign res_load      = (state == ST_DONE) && (!res_valid || result.ready);
  assign request.ready = (state == ST_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (request.valid) begin
            d     <= request.start_day;
            m     <= request.start_month;
            y     <= request.start_year;
            ypos  <= request.start_year;
            rem   <= request.days_to_add;
            bad   <= 1'b0;
            ovf   <= 1'b0;
            state <= ST_MOD;
          end
        end
        ST_MOD: begin
          if (!sub_borrow) begin
            ypos <= sub_diff[YEAR_W-1:0];
          end else begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          bad   <= start_bad;
          state <= start_bad ? ST_DONE : ST_WALK;
        end
        ST_WALK: begin
          priority if (rem == '0) begin
            state <= ST_DONE;
          end else if (!sub_borrow) begin
            // count reaches past this month: go to the first of the next
            rem <= sub_diff[COUNT_W-1:0];
            d   <= DAY_FIRST;
            if (m == MONTH_DEC) begin
              if (y == YEAR_MAX) begin
                d     <= DAY_LAST_DEC;
                ovf   <= 1'b1;
                state <= ST_DONE;
              end else begin
                m    <= MONTH_JAN;
                y    <= y + 1'b1;
                ypos <= (ypos[CYCLE_W-1:0] == CYCLE_LAST) ? '0 : ypos + 1'b1;
              end
            end else begin
              m <= m + 1'b1;
            end
          end else begin
            // rest of the count fits inside this month
            d     <= d + rem[DAY_W-1:0];
            rem   <= '0;
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result.result_day    <= d;
      result.result_month  <= m;
      result.result_year   <= y;
      result.bad_start     <= bad;
      result.year_overflow <= ovf;
    end
  end

  assign result.valid = res_valid;

`ifndef ASSERT_OFF
  // an accepted request starts the year reduction
  a_start: assert property (@(posedge clk) disable iff (rst)
    request.valid && request.ready |=> state == ST_MOD)
    else $error("accepted request did not start the sequencer");

  // the two flags never come together
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.bad_start && result.year_overflow))
    else $error("bad_start and year_overflow both set");

  // the walk only ever sits on a valid month and day
  a_walk: assert property (@(posedge clk) disable iff (rst)
    state == ST_WALK |-> (m >= MONTH_JAN) && (m <= MONTH_DEC) && (d != '0) &&
                         (d <= mlen) && (y <= YEAR_MAX) && (ypos < LEAP_CYCLE))
    else $error("walk position out of range");

  // a result is only loaded from the done state
  a_load: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_DONE)
    else $error("result loaded outside the done state");
`endif

endmodule
